// ----- sv/pfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types and constants for the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

   localparam int NumFramesDefault = 32;
   localparam int MaxPagesDefault  = 16;

   localparam int OwnerW = 8;
   localparam int CountW = 5;
   localparam int FrameW = 5;
   localparam int PageW  = 4;

   localparam logic OpAlloc = 1'b0;
   localparam logic OpFree  = 1'b1;

   localparam logic StatusOk      = 1'b0;
   localparam logic StatusNoSpace = 1'b1;

   // command kinds handed from the front to the back end
   typedef enum logic [1:0] {
      CMD_REPLY,
      CMD_FREE,
      CMD_ALLOC
   } cmd_kind_type;

   typedef struct packed {
      logic [PageW-1:0]  page_index;
      logic              status;
      logic [FrameW-1:0] frame_index;
      logic              frame_valid;
      logic              last;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [OwnerW-1:0] owner;
      logic [CountW-1:0] count;
      logic [FrameW-1:0] frame;
      rsp_type           reply;
   } cmd_type;

endpackage
`default_nettype wire

// ----- sv/pfa_channels.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa channels
// Request and response valid/ready channels of the page frame allocator.
// ----------------------------------------------------------------------------
interface pfa_req_if;
   import pfa_pkg::*;
   logic              valid;
   logic              ready;
   logic              operation;
   logic [OwnerW-1:0] owner_id;
   logic [CountW-1:0] page_count;
   logic [FrameW-1:0] freed_frame;
   logic              free_last;

   modport source (output valid, operation, owner_id, page_count, freed_frame,
                   free_last, input ready);
   modport sink   (input valid, operation, owner_id, page_count, freed_frame,
                   free_last, output ready);
endinterface

interface pfa_rsp_if;
   import pfa_pkg::*;
   logic              valid;
   logic              ready;
   logic              status;
   logic [PageW-1:0]  page_index;
   logic [FrameW-1:0] frame_index;
   logic              frame_valid;
   logic              last;

   modport source (output valid, status, page_index, frame_index, frame_valid,
                   last, input ready);
   modport sink   (input valid, status, page_index, frame_index, frame_valid,
                   last, output ready);
endinterface
`default_nettype wire

// ----- sv/page_frame_allocator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A free or an immediate reply (zero count, count above the page limit) passes
//   through the command queue and the response register before it is valid on rsp.
// Allocate: a count pass over up to NUM_FRAMES frames, then a claim pass over up to
//   NUM_FRAMES frames giving one response per page.
// The back end works on one request at a time, with two more queued in front.
// Reset (synchronous): all frames free, queue and response register empty.
// ----------------------------------------------------------------------------
// page_frame_allocator_core
// First-fit page frame allocator: front classifier, command queue, back end.
// ----------------------------------------------------------------------------
module page_frame_allocator_core
   import pfa_pkg::*;
#(
   parameter int NUM_FRAMES = NumFramesDefault,
   parameter int MAX_PAGES  = MaxPagesDefault
) (
   input  logic      clock,
   input  logic      reset,
   pfa_req_if.sink   req_ch,
   pfa_rsp_if.source rsp_ch
);

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   pfa_front #(
      .NUM_FRAMES (NUM_FRAMES),
      .MAX_PAGES  (MAX_PAGES)
   ) u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   pfa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   pfa_back #(
      .NUM_FRAMES (NUM_FRAMES),
      .MAX_PAGES  (MAX_PAGES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd       (pop_cmd),
      .rsp_ch    (rsp_ch)
   );

endmodule
`default_nettype wire

// ----- sv/pfa_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_front
// Takes requests and sorts them into immediate replies, frees and allocations.
// ----------------------------------------------------------------------------
module pfa_front
   import pfa_pkg::*;
#(
   parameter int NUM_FRAMES = NumFramesDefault,
   parameter int MAX_PAGES  = MaxPagesDefault
) (
   pfa_req_if.sink  req_ch,
   output logic     push_valid,
   input  logic     push_ready,
   output cmd_type  push_cmd
);

   logic in_range;
   logic too_many;

   assign in_range   = int'(req_ch.freed_frame) < NUM_FRAMES;
   assign too_many   = int'(req_ch.page_count) > MAX_PAGES;
   assign push_valid = req_ch.valid;
   assign req_ch.ready = push_ready;

   always_comb begin
      push_cmd                   = '0;
      push_cmd.owner             = req_ch.owner_id;
      push_cmd.count             = req_ch.page_count;
      push_cmd.frame             = req_ch.freed_frame;
      push_cmd.reply.status      = StatusOk;
      push_cmd.reply.page_index  = '0;
      push_cmd.reply.frame_index = '0;
      push_cmd.reply.frame_valid = 1'b0;
      push_cmd.reply.last        = 1'b1;
      if (req_ch.operation == OpFree) begin
         push_cmd.kind              = in_range ? CMD_FREE : CMD_REPLY;
         push_cmd.reply.frame_index = req_ch.freed_frame;
         push_cmd.reply.frame_valid = in_range;
         push_cmd.reply.last        = req_ch.free_last;
      end else if (req_ch.page_count == '0) begin
         push_cmd.kind = CMD_REPLY;
      end else if (too_many) begin
         push_cmd.kind         = CMD_REPLY;
         push_cmd.reply.status = StatusNoSpace;
      end else begin
         push_cmd.kind = CMD_ALLOC;
      end
   end

endmodule
`default_nettype wire

// ----- sv/pfa_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module pfa_queue
   import pfa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type    data_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign push_ready = fill_ff != 2'd2;
   assign pop_valid  = fill_ff != 2'd0;
   assign pop_cmd    = data_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ----- sv/pfa_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pfa_back
// Frame table and sequencer: replies, frees; counts free frames, then claims.
// ----------------------------------------------------------------------------
module pfa_back
   import pfa_pkg::*;
#(
   parameter int NUM_FRAMES = NumFramesDefault,
   parameter int MAX_PAGES  = MaxPagesDefault
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     cmd_valid,
   output logic     cmd_ready,
   input  cmd_type  cmd,
   pfa_rsp_if.source rsp_ch
);

   localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CW = $clog2(MAX_PAGES + 1);
   localparam logic [FW-1:0] LastFrame = FW'(NUM_FRAMES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_NOSPACE,
      ST_CLAIM
   } state_type;

   state_type               state_ff, state_in;
   logic [FW-1:0]           idx_ff, idx_in;
   logic [CW-1:0]           found_ff, found_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [OwnerW-1:0]       owner_ff, owner_in;
   logic [NUM_FRAMES-1:0]   used_ff, used_in;
   logic                    out_valid_ff, out_valid_in;
   rsp_type                 out_ff, out_in;
   logic [OwnerW-1:0]       owner_mem [NUM_FRAMES];
   logic                    own_we;
   logic                    slot_free;
   logic                    cur_free;
   logic [CW-1:0]           found_next;

   assign slot_free  = !out_valid_ff || rsp_ch.ready;
   assign cur_free   = !used_ff[idx_ff];
   assign found_next = CW'(found_ff + 1'b1);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      owner_in     = owner_ff;
      used_in      = used_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_in       = out_ff;
      cmd_ready    = 1'b0;
      own_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == CMD_ALLOC) begin
                  cmd_ready = 1'b1;
                  count_in  = CW'(cmd.count);
                  owner_in  = cmd.owner;
                  idx_in    = '0;
                  found_in  = '0;
                  state_in  = ST_COUNT;
               end else if (slot_free) begin
                  cmd_ready    = 1'b1;
                  out_valid_in = 1'b1;
                  out_in       = cmd.reply;
                  if (cmd.kind == CMD_FREE) begin
                     used_in[FW'(cmd.frame)] = 1'b0;
                  end
               end
            end
         end
         ST_COUNT: begin
            if (cur_free && found_next == count_ff) begin
               idx_in   = '0;
               found_in = '0;
               state_in = ST_CLAIM;
            end else if (idx_ff == LastFrame) begin
               state_in = ST_NOSPACE;
            end else begin
               idx_in = idx_ff + 1'b1;
               if (cur_free) begin
                  found_in = found_next;
               end
            end
         end
         ST_NOSPACE: begin
            if (slot_free) begin
               out_valid_in       = 1'b1;
               out_in             = '0;
               out_in.status      = StatusNoSpace;
               out_in.last        = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_CLAIM: begin
            // enough free frames were seen in the count pass, so idx never wraps
            if (!cur_free) begin
               idx_in = idx_ff + 1'b1;
            end else if (slot_free) begin
               used_in[idx_ff]    = 1'b1;
               own_we             = 1'b1;
               out_valid_in       = 1'b1;
               out_in.status      = StatusOk;
               out_in.page_index  = PageW'(found_ff);
               out_in.frame_index = FrameW'(idx_ff);
               out_in.frame_valid = 1'b1;
               out_in.last        = found_next == count_ff;
               if (found_next == count_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  found_in = found_next;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
         found_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
      end
      count_ff <= count_in;
      owner_ff <= owner_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (own_we) begin
         owner_mem[idx_ff] <= owner_ff;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.status      = out_ff.status;
   assign rsp_ch.page_index  = out_ff.page_index;
   assign rsp_ch.frame_index = out_ff.frame_index;
   assign rsp_ch.frame_valid = out_ff.frame_valid;
   assign rsp_ch.last        = out_ff.last;

endmodule
`default_nettype wire

// ----- test/page_frame_allocator_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator_checker
// Watches the request and response channels of the page frame allocator. It
// keeps its own first-fit frame table, works out the responses that each
// request must produce, and compares every response with the oldest one due.
// ----------------------------------------------------------------------------
module page_frame_allocator_checker
   import pfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pfa_req_if          req_mon,
   pfa_rsp_if          rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending
);

   localparam int Frames = NumFramesDefault;
   localparam int Pages  = MaxPagesDefault;

   logic              frame_taken [Frames];
   logic [OwnerW-1:0] frame_holder[Frames];
   rsp_type           expected_replies[$];

   function automatic rsp_type make_reply(logic status, int page, int frame,
                                          logic fvalid, logic last);
      rsp_type r;
      r.status      = status;
      r.page_index  = PageW'(page);
      r.frame_index = FrameW'(frame);
      r.frame_valid = fvalid;
      r.last        = last;
      return r;
   endfunction

   // first-fit placement: the lowest free frames, or nothing at all
   task automatic place_request(input logic op, input logic [OwnerW-1:0] owner,
                                input logic [CountW-1:0] count,
                                input logic [FrameW-1:0] frame, input logic flast);
      int unsigned picked[$];
      if (op == OpFree) begin
         if (int'(frame) < Frames) frame_taken[frame] = 1'b0;
         expected_replies.push_back(make_reply(StatusOk, 0, frame,
                                               int'(frame) < Frames, flast));
      end else if (count == 0) begin
         expected_replies.push_back(make_reply(StatusOk, 0, 0, 1'b0, 1'b1));
      end else begin
         for (int i = 0; i < Frames && picked.size() < count; i++)
            if (!frame_taken[i]) picked.push_back(i);
         if (count > Pages || picked.size() < count) begin
            expected_replies.push_back(make_reply(StatusNoSpace, 0, 0, 1'b0, 1'b1));
         end else begin
            foreach (picked[i]) begin
               frame_taken[picked[i]]  = 1'b1;
               frame_holder[picked[i]] = owner;
               expected_replies.push_back(make_reply(StatusOk, i, picked[i], 1'b1,
                                                     i == picked.size() - 1));
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         expected_replies.delete();
         foreach (frame_taken[f]) frame_taken[f] = 1'b0;
         fail_count <= 0;
         pending    <= 0;
      end else begin
         // responses first: a request taken at this edge cannot answer at it
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status      = rsp_mon.status;
            got.page_index  = rsp_mon.page_index;
            got.frame_index = rsp_mon.frame_index;
            got.frame_valid = rsp_mon.frame_valid;
            got.last        = rsp_mon.last;
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected response: expected none, got status=%0d",
                        $time, got.status, " page=%0d frame=%0d valid=%0d last=%0d",
                        got.page_index, got.frame_index, got.frame_valid, got.last);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_replies.pop_front();
               if (got !== want) begin
                  $display("%0t: response mismatch: expected status=%0d page=%0d",
                           $time, want.status, want.page_index,
                           " frame=%0d valid=%0d last=%0d", want.frame_index,
                           want.frame_valid, want.last);
                  $display("%0t:                    actual   status=%0d page=%0d",
                           $time, got.status, got.page_index,
                           " frame=%0d valid=%0d last=%0d", got.frame_index,
                           got.frame_valid, got.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            place_request(req_mon.operation, req_mon.owner_id, req_mon.page_count,
                          req_mon.freed_frame, req_mon.free_last);
         pending <= expected_replies.size();
      end
   end

endmodule

// ----- test/page_frame_allocator_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator_core_tb
// Drives allocate and free requests into the page frame allocator: a directed
// pass over full, empty and refused cases, then random allocations mixed with
// runs of frame releases. Both channels idle at random; the checker beside
// the block predicts and compares every response.
// ----------------------------------------------------------------------------
module page_frame_allocator_core_tb;
   import pfa_pkg::*;

   localparam int TotalRequests = 430;
   localparam int SettleCycles  = 80;

   logic        clock;
   logic        reset;
   bit          steady;
   int unsigned requests_issued;
   int unsigned fail_count;
   int unsigned pending;

   pfa_req_if req_ch ();
   pfa_rsp_if rsp_ch ();

   page_frame_allocator_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   page_frame_allocator_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int unsigned draw_gap();
      return steady ? 0 : $urandom_range(0, 16);
   endfunction

   task automatic issue_request(input logic op, input logic [OwnerW-1:0] owner,
                                input logic [CountW-1:0] count,
                                input logic [FrameW-1:0] frame, input logic flast);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.owner_id    <= owner;
      req_ch.page_count  <= count;
      req_ch.freed_frame <= frame;
      req_ch.free_last   <= flast;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      requests_issued++;
   endtask

   // unused fields carry random noise
   task automatic request_pages(input int owner, input int count);
      issue_request(OpAlloc, OwnerW'(owner), CountW'(count),
                    FrameW'($urandom), 1'($urandom));
   endtask

   task automatic release_frame(input int frame, input logic flast);
      issue_request(OpFree, OwnerW'($urandom), CountW'($urandom), FrameW'(frame),
                    flast);
   endtask

   task automatic drain_replies();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // response side: fresh stall before every response
   initial begin
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = draw_gap();
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   initial begin
      int unsigned pick;
      int unsigned start;
      int unsigned run_len;
      int unsigned count;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.operation   <= OpAlloc;
      req_ch.owner_id    <= '0;
      req_ch.page_count  <= '0;
      req_ch.freed_frame <= '0;
      req_ch.free_last   <= 1'b0;
      requests_issued = 0;
      steady = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, fill to the brim, refusals, releases
      request_pages(0, 0);
      request_pages(255, 1);
      request_pages(8'hA5, 16);
      request_pages(8'h5A, 16);     // one frame short
      request_pages(8'h3C, 15);     // table now full
      request_pages(8'hC3, 1);
      request_pages(8'h01, 17);     // above the page limit
      request_pages(8'hFE, 31);
      release_frame(31, 1'b0);
      release_frame(0, 1'b1);
      release_frame(5, 1'b1);
      release_frame(0, 1'b0);       // already free
      request_pages(8'h77, 3);
      drain_replies();
      for (int f = 1; f <= 4; f++) release_frame(f, f == 4);
      request_pages(8'h88, 4);
      steady = 1'b1;
      for (int f = 16; f <= 20; f++) release_frame(f, f == 20);
      request_pages(8'h42, 16);
      steady = 1'b0;

      while (requests_issued < TotalRequests) begin
         if ($urandom_range(0, 11) == 0) steady = !steady;
         if ($urandom_range(0, 24) == 0) drain_replies();
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            case ($urandom_range(0, 19))
               0:       count = 0;
               1:       count = $urandom_range(17, 31);
               2, 3, 4: count = $urandom_range(9, 16);
               default: count = $urandom_range(1, 8);
            endcase
            request_pages($urandom_range(0, 255), count);
         end else if (pick < 9) begin
            start   = $urandom_range(0, 31);
            run_len = $urandom_range(1, 6);
            for (int k = 0; k < run_len; k++)
               release_frame((start + k) % 32, k == run_len - 1);
         end else begin
            release_frame($urandom_range(0, 31), 1'($urandom));
         end
      end

      drain_replies();
      repeat (SettleCycles) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
